@@ rtl/core/dpc_pkg.sv @@
// Shared types and constants for the disc point classifier.
package dpc_pkg;

   // Fixed field widths of the register set.
   localparam int NORMAL_W = 16;
   localparam int RADIUS_W = 31;
   localparam int TOL_W    = 16;

   // Q2.14 products are brought back to Q16.16 by this shift, rounding half up.
   localparam int FRAC_SHIFT = 14;

   // Reset values of the registers that do not reset to zero.
   localparam logic [NORMAL_W-1:0] NORMAL_Z_RESET = 16'd16384;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET   = 31'd65536;
   localparam logic [TOL_W-1:0]    TOL_RESET      = 16'd1;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_CENTER_X  = 3'd0,
      REG_CENTER_Y  = 3'd1,
      REG_CENTER_Z  = 3'd2,
      REG_NORMAL_X  = 3'd3,
      REG_NORMAL_Y  = 3'd4,
      REG_NORMAL_Z  = 3'd5,
      REG_RADIUS    = 3'd6,
      REG_TOLERANCE = 3'd7
   } csr_index_type;

   // Classification codes.
   typedef enum logic [1:0] {
      DIR_OUTER  = 2'd0,
      DIR_BORDER = 2'd1,
      DIR_INNER  = 2'd2
   } direction_type;

endpackage

@@ rtl/core/disc_point_classify_core.sv @@
// An accepted point word moves through the stage registers to its result word on rsp_.
// Throughput: one point per cycle while rsp_stall is low; a nine-stage pipeline with
// per-stage valid bits closes bubbles under a result stall, and a one-word skid buffer
// drives req_stall from a register. Reset clears all valid bits and loads the register
// defaults: centre at the origin, normal (0, 0, 1.0), radius 1.0, tolerance 1.
module disc_point_classify_core
   import dpc_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // Point words in.
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COORD_WIDTH-1:0] req_point_x,
   input  logic [COORD_WIDTH-1:0] req_point_y,
   input  logic [COORD_WIDTH-1:0] req_point_z,
   // Classification words out.
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_direction,
   // Register writes.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] csr_wdata
);

   // Derived widths of the datapath.
   localparam int CW    = COORD_WIDTH;
   localparam int PW    = CW + 1;                 // offset from the centre
   localparam int PK    = (PW + 1) / 2;           // low half of an offset square
   localparam int PHW   = PW - PK;
   localparam int PNW   = PW + NORMAL_W;          // offset times normal
   localparam int DOTW  = PNW + 2;
   localparam int TW    = DOTW - FRAC_SHIFT;      // signed height
   localparam int TNW   = TW + NORMAL_W;
   localparam int RTW   = TNW - FRAC_SHIFT;
   localparam int QW    = RTW + 1;                // in-plane vector
   localparam int QK    = (QW + 1) / 2;
   localparam int QHW   = QW - QK;
   localparam int PSW   = 2 * PW;
   localparam int PPW   = PSW + 2;
   localparam int QSW   = 2 * QW;
   localparam int D2W   = QSW + 2;
   localparam int R2W   = 2 * RADIUS_W;
   localparam int LIMW  = R2W + 1;
   localparam int DIFFW = ((PPW > R2W) ? PPW : R2W) + 1;
   localparam int CMPW  = ((D2W > LIMW) ? D2W : LIMW) + 1;
   localparam logic [DOTW-1:0] DOT_HALF = DOTW'(1) << (FRAC_SHIFT - 1);
   localparam logic [TNW-1:0]  TN_HALF  = TNW'(1) << (FRAC_SHIFT - 1);

   // ---------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------
   logic [CW-1:0]       center_ff [3];
   logic [NORMAL_W-1:0] normal_ff [3];
   logic [RADIUS_W-1:0] radius_ff;
   logic [TOL_W-1:0]    tol_ff;

   assign csr_ready = 1'b1;

   // Register writes; every index of the three-bit field names a register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            center_ff[i] <= '0;
         end
         normal_ff[0] <= '0;
         normal_ff[1] <= '0;
         normal_ff[2] <= NORMAL_Z_RESET;
         radius_ff    <= RADIUS_RESET;
         tol_ff       <= TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            REG_CENTER_X:  center_ff[0] <= csr_wdata[CW-1:0];
            REG_CENTER_Y:  center_ff[1] <= csr_wdata[CW-1:0];
            REG_CENTER_Z:  center_ff[2] <= csr_wdata[CW-1:0];
            REG_NORMAL_X:  normal_ff[0] <= csr_wdata[NORMAL_W-1:0];
            REG_NORMAL_Y:  normal_ff[1] <= csr_wdata[NORMAL_W-1:0];
            REG_NORMAL_Z:  normal_ff[2] <= csr_wdata[NORMAL_W-1:0];
            REG_RADIUS:    radius_ff    <= csr_wdata[RADIUS_W-1:0];
            REG_TOLERANCE: tol_ff       <= csr_wdata[TOL_W-1:0];
            default:       radius_ff    <= radius_ff;
         endcase
      end
   end

   // Radius squared and the outer limit, it plus the tolerance, are each registered.
   // They are first read in the last two stages, long after a write settles.
   logic [R2W-1:0]  r2_ff;
   logic [LIMW-1:0] lim_ff;

   always_ff @(posedge clock) begin
      r2_ff  <= radius_ff * radius_ff;
      lim_ff <= {1'b0, r2_ff} + LIMW'(tol_ff);
   end

   // ---------------------------------------------------------------
   // Stage enables: a stage loads when it is empty or the next one loads.
   // ---------------------------------------------------------------
   logic [9:1] valid_ff;
   logic [9:1] en;
   logic       skid_valid_ff;
   logic       in_valid;

   always_comb begin
      en[9] = !valid_ff[9] || !rsp_stall;
      for (int k = 8; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign in_valid  = skid_valid_ff || req_valid;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = valid_ff[9];

   // Valid bits travel with the data; the skid fills when stage 1 cannot load.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (en[1]) begin
            valid_ff[1] <= in_valid;
         end
         for (int k = 2; k <= 9; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
         if (skid_valid_ff) begin
            skid_valid_ff <= !en[1];
         end else begin
            skid_valid_ff <= req_valid && !en[1];
         end
      end
   end

   // Skid buffer for the input word.
   logic [CW-1:0] skid_pt_ff [3];
   logic [CW-1:0] pt_src [3];

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_pt_ff[0] <= req_point_x;
         skid_pt_ff[1] <= req_point_y;
         skid_pt_ff[2] <= req_point_z;
      end
   end

   assign pt_src[0] = skid_valid_ff ? skid_pt_ff[0] : req_point_x;
   assign pt_src[1] = skid_valid_ff ? skid_pt_ff[1] : req_point_y;
   assign pt_src[2] = skid_valid_ff ? skid_pt_ff[2] : req_point_z;

   // ---------------------------------------------------------------
   // Stage 1: offset from the centre.
   // ---------------------------------------------------------------
   logic signed [PW-1:0] p1_in [3];
   logic signed [PW-1:0] p1_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1_in[i] = $signed({pt_src[i][CW-1], pt_src[i]})
                  - $signed({center_ff[i][CW-1], center_ff[i]});
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: offset times normal, and the partial products of the offset square.
   // ---------------------------------------------------------------
   logic signed [PNW-1:0]     pn2_in [3];
   logic signed [2*PHW-1:0]   phh2_in [3];
   logic signed [PW:0]        phl2_in [3];
   logic        [2*PK-1:0]    pll2_in [3];
   logic signed [PHW-1:0]     p1_hi [3];
   logic        [PK-1:0]      p1_lo [3];
   logic signed [PNW-1:0]     pn2_ff [3];
   logic signed [2*PHW-1:0]   phh2_ff [3];
   logic signed [PW:0]        phl2_ff [3];
   logic        [2*PK-1:0]    pll2_ff [3];
   logic signed [PW-1:0]      p2_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1_hi[i]   = p1_ff[i][PW-1:PK];
         p1_lo[i]   = p1_ff[i][PK-1:0];
         pn2_in[i]  = p1_ff[i] * $signed(normal_ff[i]);
         phh2_in[i] = p1_hi[i] * p1_hi[i];
         phl2_in[i] = p1_hi[i] * $signed({1'b0, p1_lo[i]});
         pll2_in[i] = p1_lo[i] * p1_lo[i];
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: height along the normal, and each offset square assembled.
   // ---------------------------------------------------------------
   logic [DOTW-1:0]       dot3;
   logic signed [TW-1:0]  t3_in;
   logic [PSW-1:0]        psq3_in [3];
   logic signed [TW-1:0]  t3_ff;
   logic [PSW-1:0]        psq3_ff [3];
   logic signed [PW-1:0]  p3_ff [3];

   always_comb begin
      dot3 = DOT_HALF;
      for (int i = 0; i < 3; i++) begin
         dot3 = dot3 + DOTW'(pn2_ff[i]);
         psq3_in[i] = {phh2_ff[i], {(2*PK){1'b0}}}
                    + {{(PSW-PK-PW-2){phl2_ff[i][PW]}}, phl2_ff[i], {(PK+1){1'b0}}}
                    + {{(PSW-2*PK){1'b0}}, pll2_ff[i]};
      end
      t3_in = dot3[DOTW-1:FRAC_SHIFT];
   end

   // ---------------------------------------------------------------
   // Stage 4: squared distance to the centre, and height times normal.
   // ---------------------------------------------------------------
   logic [PPW-1:0]        pp4_in;
   logic signed [TNW-1:0] tn4_in [3];
   logic [PPW-1:0]        pp4_ff;
   logic signed [TNW-1:0] tn4_ff [3];
   logic signed [TW-1:0]  t4_ff;
   logic signed [PW-1:0]  p4_ff [3];

   always_comb begin
      pp4_in = '0;
      for (int i = 0; i < 3; i++) begin
         pp4_in    = pp4_in + {{(PPW-PSW){1'b0}}, psq3_ff[i]};
         tn4_in[i] = t3_ff * $signed(normal_ff[i]);
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: in-plane vector, offset less the rounded normal part.
   // ---------------------------------------------------------------
   logic [TNW-1:0]       tn4_r [3];
   logic [QW-1:0]        q5_in [3];
   logic [QW-1:0]        q5_ff [3];
   logic [PPW-1:0]       pp5_ff;
   logic signed [TW-1:0] t5_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tn4_r[i] = tn4_ff[i] + TN_HALF;
         q5_in[i] = QW'(p4_ff[i]) - QW'($signed(tn4_r[i][TNW-1:FRAC_SHIFT]));
      end
   end

   // ---------------------------------------------------------------
   // Stage 6: partial products of the in-plane squares.
   // ---------------------------------------------------------------
   logic signed [QHW-1:0]   q5_hi [3];
   logic        [QK-1:0]    q5_lo [3];
   logic signed [2*QHW-1:0] qhh6_in [3];
   logic signed [QW:0]      qhl6_in [3];
   logic        [2*QK-1:0]  qll6_in [3];
   logic signed [2*QHW-1:0] qhh6_ff [3];
   logic signed [QW:0]      qhl6_ff [3];
   logic        [2*QK-1:0]  qll6_ff [3];
   logic [PPW-1:0]          pp6_ff;
   logic signed [TW-1:0]    t6_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q5_hi[i]   = $signed(q5_ff[i][QW-1:QK]);
         q5_lo[i]   = q5_ff[i][QK-1:0];
         qhh6_in[i] = q5_hi[i] * q5_hi[i];
         qhl6_in[i] = q5_hi[i] * $signed({1'b0, q5_lo[i]});
         qll6_in[i] = q5_lo[i] * q5_lo[i];
      end
   end

   // ---------------------------------------------------------------
   // Stage 7: each in-plane square assembled.
   // ---------------------------------------------------------------
   logic [QSW-1:0]       qsq7_in [3];
   logic [QSW-1:0]       qsq7_ff [3];
   logic [PPW-1:0]       pp7_ff;
   logic signed [TW-1:0] t7_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qsq7_in[i] = {qhh6_ff[i], {(2*QK){1'b0}}}
                    + {{(QSW-QK-QW-2){qhl6_ff[i][QW]}}, qhl6_ff[i], {(QK+1){1'b0}}}
                    + {{(QSW-2*QK){1'b0}}, qll6_ff[i]};
      end
   end

   // ---------------------------------------------------------------
   // Stage 8: in-plane distance squared, plane test and border test.
   // ---------------------------------------------------------------
   logic [D2W-1:0]          d2_8_in;
   logic signed [TW-1:0]    tol_t;
   logic signed [DIFFW-1:0] tol_d;
   logic signed [DIFFW-1:0] diff8;
   logic                    off8_in;
   logic                    bord8_in;
   logic [D2W-1:0]          d2_8_ff;
   logic                    off8_ff;
   logic                    bord8_ff;

   always_comb begin
      d2_8_in = '0;
      for (int i = 0; i < 3; i++) begin
         d2_8_in = d2_8_in + {{(D2W-QSW){1'b0}}, qsq7_ff[i]};
      end
      tol_t    = $signed({{(TW-TOL_W){1'b0}}, tol_ff});
      tol_d    = $signed({{(DIFFW-TOL_W){1'b0}}, tol_ff});
      off8_in  = (t7_ff > tol_t) || (t7_ff < -tol_t);
      diff8    = $signed({{(DIFFW-PPW){pp7_ff[PPW-1]}}, pp7_ff})
               - $signed({{(DIFFW-R2W){1'b0}}, r2_ff});
      bord8_in = !(diff8 > tol_d) && !(diff8 < -tol_d);
   end

   // ---------------------------------------------------------------
   // Stage 9: classification into the output register.
   // ---------------------------------------------------------------
   direction_type dir9_in;
   direction_type dir9_ff;
   logic          far9;

   always_comb begin
      far9 = $signed({{(CMPW-D2W){1'b0}}, d2_8_ff}) > $signed({{(CMPW-LIMW){1'b0}}, lim_ff});
      priority if (far9) begin
         dir9_in = DIR_OUTER;
      end else if (off8_ff) begin
         dir9_in = DIR_OUTER;
      end else if (bord8_ff) begin
         dir9_in = DIR_BORDER;
      end else begin
         dir9_in = DIR_INNER;
      end
   end

   assign rsp_direction = dir9_ff;

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         p1_ff <= p1_in;
      end
      if (en[2]) begin
         pn2_ff  <= pn2_in;
         phh2_ff <= phh2_in;
         phl2_ff <= phl2_in;
         pll2_ff <= pll2_in;
         p2_ff   <= p1_ff;
      end
      if (en[3]) begin
         t3_ff   <= t3_in;
         psq3_ff <= psq3_in;
         p3_ff   <= p2_ff;
      end
      if (en[4]) begin
         pp4_ff <= pp4_in;
         tn4_ff <= tn4_in;
         t4_ff  <= t3_ff;
         p4_ff  <= p3_ff;
      end
      if (en[5]) begin
         q5_ff  <= q5_in;
         pp5_ff <= pp4_ff;
         t5_ff  <= t4_ff;
      end
      if (en[6]) begin
         qhh6_ff <= qhh6_in;
         qhl6_ff <= qhl6_in;
         qll6_ff <= qll6_in;
         pp6_ff  <= pp5_ff;
         t6_ff   <= t5_ff;
      end
      if (en[7]) begin
         qsq7_ff <= qsq7_in;
         pp7_ff  <= pp6_ff;
         t7_ff   <= t6_ff;
      end
      if (en[8]) begin
         d2_8_ff  <= d2_8_in;
         off8_ff  <= off8_in;
         bord8_ff <= bord8_in;
      end
      if (en[9]) begin
         dir9_ff <= dir9_in;
      end
   end

   // ---------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------

   // The skid buffer only holds a word while stage 1 is occupied.
   a_skid_backed: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> valid_ff[1])
      else $error("skid buffer full with stage 1 empty");

   // A word leaving stage 8 always reaches the output register.
   a_stage8_moves: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[8] && en[9]) |=> rsp_valid)
      else $error("word lost between stage 8 and the output");

   // A point off the plane is always classified outer.
   a_off_plane_outer: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[8] && en[9] && off8_ff) |=> (rsp_direction == DIR_OUTER))
      else $error("off-plane point not classified outer");

   // A point beyond the radius limit is never border nor inner.
   a_far_outer: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[8] && en[9] && far9) |=> (rsp_direction == DIR_OUTER))
      else $error("distant point not classified outer");

endmodule

@@ tb/tb_disc_point_classify_core.sv @@
// Self-checking disc point classifier testbench: corner cases, then random points and discs.
module tb_disc_point_classify_core
   import dpc_pkg::*;
();

   localparam int COORD_W         = 32;
   localparam int RESET_CYCLES    = 12;
   localparam int DRAIN_CYCLES    = 16;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 108;
   localparam int CYCLE_LIMIT     = 300000;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } point_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [COORD_W-1:0] req_point_x = '0;
   logic [COORD_W-1:0] req_point_y = '0;
   logic [COORD_W-1:0] req_point_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_direction;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   // Points waiting to be sent, and classifications waiting to come back.
   point_word_type point_queue [$];
   direction_type  direction_queue [$];

   // Our own copy of the register file, held at each register's width.
   logic [31:0] reg_file [8];

   int             idle_pct = 0;
   int             stall_pct = 0;
   int             send_gap = 0;
   int             stall_left = 0;
   int             error_count = 0;
   int unsigned    cycle_count = 0;
   point_word_type next_point;
   direction_type  expected_dir;

   disc_point_classify_core #(
      .COORD_WIDTH(COORD_W)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_point_z  (req_point_z),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_direction(rsp_direction),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Classifies one point against the current disc, with exact wide arithmetic.
   function automatic direction_type classify_point(logic [31:0] px, logic [31:0] py,
                                                    logic [31:0] pz);
      logic signed [127:0] offs [3];
      logic signed [127:0] nrm [3];
      logic signed [127:0] height_acc, offs_len2, plane_len2, in_plane, height;
      logic signed [127:0] rad, rad2, tol_w, bound, dev;
      logic signed [31:0]  coord, centre_c;
      logic signed [15:0]  n16;
      logic [31:0]         pt [3];
      int                  k;
      pt[0] = px;
      pt[1] = py;
      pt[2] = pz;
      height_acc = 0;
      offs_len2  = 0;
      plane_len2 = 0;
      for (k = 0; k < 3; k++) begin
         coord    = pt[k];
         centre_c = reg_file[REG_CENTER_X + k];
         n16      = reg_file[REG_NORMAL_X + k][15:0];
         offs[k]  = coord;
         offs[k]  = offs[k] - centre_c;
         nrm[k]   = n16;
         height_acc = height_acc + offs[k] * nrm[k];
         offs_len2  = offs_len2 + offs[k] * offs[k];
      end
      // Height along the normal, brought back to Q16.16 with rounding half up.
      height = (height_acc + 128'sd8192) >>> FRAC_SHIFT;
      for (k = 0; k < 3; k++) begin
         in_plane   = offs[k] - ((height * nrm[k] + 128'sd8192) >>> FRAC_SHIFT);
         plane_len2 = plane_len2 + in_plane * in_plane;
      end
      rad   = {97'd0, reg_file[REG_RADIUS][RADIUS_W-1:0]};
      tol_w = {112'd0, reg_file[REG_TOLERANCE][TOL_W-1:0]};
      rad2  = rad * rad;
      bound = rad2 + tol_w;
      if (plane_len2 > bound) begin
         return DIR_OUTER;
      end
      if (height > tol_w || height < -tol_w) begin
         return DIR_OUTER;
      end
      dev = offs_len2 - rad2;
      if (dev > tol_w || dev < -tol_w) begin
         return DIR_INNER;
      end
      return DIR_BORDER;
   endfunction

   function automatic real signed_unit();
      return real'(int'($urandom_range(2000)) - 1000) / 1000.0;
   endfunction

   function automatic void add_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      point_queue.push_back('{x: px, y: py, z: pz});
   endfunction

   // Writes one register while the block is idle; bits above its width carry filler.
   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      logic [31:0] keep_mask;
      int          bits;
      case (idx)
         REG_NORMAL_X, REG_NORMAL_Y, REG_NORMAL_Z: bits = NORMAL_W;
         REG_RADIUS:                               bits = RADIUS_W;
         REG_TOLERANCE:                            bits = TOL_W;
         default:                                  bits = 32;
      endcase
      keep_mask = (bits == 32) ? '1 : ((32'd1 << bits) - 32'd1);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (value & keep_mask) | ($urandom() & ~keep_mask);
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      reg_file[idx] = value & keep_mask;
   endtask

   // Waits until every point has gone in and every classification has come out.
   // The queues and the valid are looked at mid-cycle, once the edge's updates have settled.
   task automatic wait_drained();
      while (point_queue.size() != 0 || req_valid || direction_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Point driver: a new word is presented only once the previous one has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            direction_queue.push_back(classify_point(req_point_x, req_point_y, req_point_z));
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (point_queue.size() != 0 && idle_pct != 0 &&
                         $urandom_range(99) < idle_pct) begin
               send_gap  <= $urandom_range(8);
               req_valid <= 1'b0;
            end else if (point_queue.size() != 0) begin
               next_point = point_queue.pop_front();
               req_valid   <= 1'b1;
               req_point_x <= next_point.x;
               req_point_y <= next_point.y;
               req_point_z <= next_point.z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor, with random stall bursts on the result side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (direction_queue.size() == 0) begin
               $error("rsp_direction: no word expected, actual %0d", rsp_direction);
               error_count++;
            end else begin
               expected_dir = direction_queue.pop_front();
               if (rsp_direction !== expected_dir) begin
                  $error("rsp_direction mismatch: expected %0d, actual %0d",
                         expected_dir, rsp_direction);
                  error_count++;
               end
            end
         end
         if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(8);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int                 phase, item, pick, axis, k, tol;
      real                nv [3];
      real                dir_v [3];
      real                len, span, lift, rad_r, w1, w2, w3;
      logic signed [15:0] n16;
      logic signed [31:0] c32;
      longint             off;
      logic [31:0]        pt_w [3];
      logic [15:0]        norm_w [3];

      // Register copy at its reset values.
      for (k = 0; k < 8; k++) reg_file[k] = '0;
      reg_file[REG_NORMAL_Z]  = {16'd0, NORMAL_Z_RESET};
      reg_file[REG_RADIUS]    = {1'b0, RADIUS_RESET};
      reg_file[REG_TOLERANCE] = {16'd0, TOL_RESET};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      idle_pct  = 30;
      stall_pct = 30;

      // Unit disc at the origin: centre, rim, outside, heights near the tolerance, extremes.
      add_point(32'd0, 32'd0, 32'd0);
      add_point(32'd65536, 32'd0, 32'd0);
      add_point(32'd0, -32'sd65536, 32'd0);
      add_point(32'd65537, 32'd0, 32'd0);
      add_point(32'd0, 32'd0, 32'd1);
      add_point(32'd0, 32'd0, -32'sd1);
      add_point(32'd0, 32'd0, 32'd2);
      add_point(32'd0, 32'd0, -32'sd2);
      add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_point(32'hFFFF_FFFF, 32'd0, 32'd0);
      add_point(32'd46341, 32'd46341, 32'd0);
      wait_drained();

      // Zero radius and zero tolerance: only the centre itself is on the border.
      write_csr(REG_RADIUS, 32'd0);
      write_csr(REG_TOLERANCE, 32'd0);
      add_point(32'd0, 32'd0, 32'd0);
      add_point(32'd1, 32'd0, 32'd0);
      add_point(32'd0, 32'd0, 32'd1);
      wait_drained();

      // Radius 5.0 with exact rims from the 3-4-5 triangle.
      write_csr(REG_RADIUS, 32'd327680);
      add_point(32'd196608, 32'd262144, 32'd0);
      add_point(32'd196608, -32'sd262144, 32'd1);
      add_point(-32'sd327680, 32'd0, 32'd0);
      add_point(32'd0, 32'd0, 32'd0);
      wait_drained();

      // Every register at an extreme, with a normal far from unit length.
      write_csr(REG_CENTER_X, 32'h7FFF_FFFF);
      write_csr(REG_CENTER_Y, 32'h8000_0000);
      write_csr(REG_CENTER_Z, 32'hFFFF_FFFF);
      write_csr(REG_NORMAL_X, 32'h0000_8000);
      write_csr(REG_NORMAL_Y, 32'h0000_7FFF);
      write_csr(REG_NORMAL_Z, 32'h0000_8000);
      write_csr(REG_RADIUS, 32'h7FFF_FFFF);
      write_csr(REG_TOLERANCE, 32'h0000_FFFF);
      add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      add_point(32'd0, 32'd0, 32'd0);
      wait_drained();

      for (phase = 0; phase < PHASES; phase++) begin
         // Normal: on an axis, a random unit vector, a fixed oblique one, or anything.
         pick = $urandom_range(99);
         norm_w = '{default: 16'd0};
         if (pick < 40) begin
            axis = $urandom_range(2);
            norm_w[axis] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
         end else if (pick < 80) begin
            w1  = signed_unit();
            w2  = signed_unit();
            w3  = signed_unit();
            len = $sqrt(w1 * w1 + w2 * w2 + w3 * w3);
            if (len < 0.05) begin
               w1  = 0.0;
               w2  = 0.0;
               w3  = 1.0;
               len = 1.0;
            end
            norm_w[0] = 16'(int'(w1 / len * 16384.0));
            norm_w[1] = 16'(int'(w2 / len * 16384.0));
            norm_w[2] = 16'(int'(w3 / len * 16384.0));
         end else if (pick < 90) begin
            case ($urandom_range(2))
               0:       norm_w = '{16'sd11585, 16'sd11585, 16'sd0};
               1:       norm_w = '{16'sd9459, -16'sd9459, 16'sd9459};
               default: norm_w = '{16'sd0, -16'sd9830, 16'sd13107};
            endcase
         end else begin
            for (k = 0; k < 3; k++) norm_w[k] = 16'($urandom());
         end
         write_csr(REG_NORMAL_X, {16'd0, norm_w[0]});
         write_csr(REG_NORMAL_Y, {16'd0, norm_w[1]});
         write_csr(REG_NORMAL_Z, {16'd0, norm_w[2]});

         // Centre mostly near the origin so that nearby points do not wrap.
         for (k = 0; k < 3; k++) begin
            pt_w[k] = ($urandom_range(3) == 0) ? $urandom() :
                      32'(int'($urandom_range(1 << 24)) - (1 << 23));
         end
         write_csr(REG_CENTER_X, pt_w[0]);
         write_csr(REG_CENTER_Y, pt_w[1]);
         write_csr(REG_CENTER_Z, pt_w[2]);

         pick = $urandom_range(99);
         if (pick < 15)      write_csr(REG_RADIUS, $urandom_range(64));
         else if (pick < 40) write_csr(REG_RADIUS, $urandom_range(1 << 16));
         else if (pick < 75) write_csr(REG_RADIUS, $urandom_range(1 << 22));
         else if (pick < 90) write_csr(REG_RADIUS, $urandom_range(1 << 28));
         else                write_csr(REG_RADIUS, 32'h7FFF_FFFF - $urandom_range(3));

         pick = $urandom_range(99);
         if (pick < 20)      write_csr(REG_TOLERANCE, 32'd0);
         else if (pick < 35) write_csr(REG_TOLERANCE, 32'd1);
         else if (pick < 75) write_csr(REG_TOLERANCE, $urandom_range(255));
         else if (pick < 90) write_csr(REG_TOLERANCE, $urandom_range(65535));
         else                write_csr(REG_TOLERANCE, 32'd65535);

         // The closing phase runs with no idling on either side.
         if (phase == PHASES - 1) begin
            idle_pct  = 0;
            stall_pct = 0;
         end else begin
            idle_pct  = 20 * $urandom_range(3);
            stall_pct = 20 * $urandom_range(3);
         end

         tol   = reg_file[REG_TOLERANCE];
         rad_r = real'(reg_file[REG_RADIUS]);
         axis  = -1;
         for (k = 0; k < 3; k++) begin
            n16   = reg_file[REG_NORMAL_X + k][15:0];
            nv[k] = real'(n16) / 16384.0;
         end
         for (k = 0; k < 3; k++) begin
            if (nv[k] != 0.0 && nv[(k + 1) % 3] == 0.0 && nv[(k + 2) % 3] == 0.0) axis = k;
         end

         for (item = 0; item < ITEMS_PER_PHASE; item++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
               // Noise over the whole coordinate range.
               add_point($urandom(), $urandom(), $urandom());
            end else begin
               // In-plane direction mixed from three tangents of the normal.
               w1 = signed_unit();
               w2 = signed_unit();
               w3 = signed_unit();
               dir_v[0] = w1 * nv[1] + w3 * nv[2];
               dir_v[1] = -w1 * nv[0] + w2 * nv[2];
               dir_v[2] = -w2 * nv[1] - w3 * nv[0];
               span = rad_r * real'($urandom_range(1300)) / 1000.0;
               lift = 0.0;
               if (pick >= 75 && axis >= 0) begin
                  // On or next to the rim along one of the two in-plane axes.
                  dir_v = '{0.0, 0.0, 0.0};
                  dir_v[(axis + 1 + $urandom_range(1)) % 3] = $urandom_range(1) ? 1.0 : -1.0;
                  span = rad_r + real'(int'($urandom_range(4)) - 2);
               end else if (pick >= 55) begin
                  // Lifted off the plane by about the tolerance.
                  lift = real'(int'($urandom_range(2 * tol + 6)) - tol - 3);
               end
               len = $sqrt(dir_v[0] * dir_v[0] + dir_v[1] * dir_v[1] + dir_v[2] * dir_v[2]);
               if (len < 1.0e-9) begin
                  dir_v = '{1.0, 0.0, 0.0};
                  len   = 1.0;
               end
               for (k = 0; k < 3; k++) begin
                  c32     = reg_file[REG_CENTER_X + k];
                  off     = longint'(dir_v[k] / len * span + nv[k] * lift);
                  pt_w[k] = 32'(longint'(c32) + off);
               end
               add_point(pt_w[0], pt_w[1], pt_w[2]);
            end
         end
         wait_drained();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ disc_point_classify_core.f @@
rtl/core/dpc_pkg.sv
rtl/core/disc_point_classify_core.sv
tb/tb_disc_point_classify_core.sv
